### rtl/crtmp_pkg.sv
`default_nettype none
package crtmp_pkg;

	localparam int WORD_BITS     = 32;
	localparam int DBL_BITS      = 2 * WORD_BITS;
	localparam int CNT_BITS      = $clog2(DBL_BITS + 1);
	localparam int IDX_BITS      = $clog2(WORD_BITS + 1);
	localparam int D_BITS        = WORD_BITS / 2 + 1;
	localparam int S_BITS        = WORD_BITS + 2;
	localparam int FIRST_DIVISOR = 2;

	typedef struct packed {
		logic                start;
		logic                wide;
		logic [DBL_BITS-1:0] dividend;
		logic [WORD_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [WORD_BITS-1:0] quo;
		logic [WORD_BITS-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic ready;
		logic done;
	} seq_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_TR_CHK, ST_TR_DIV, ST_TR_W, ST_FA_DIV, ST_FA_W, ST_TAIL,
		ST_CO_DIV, ST_CO_W, ST_XM_DIV, ST_XM_W, ST_PW_CHK, ST_PW_MDIV, ST_PW_MW,
		ST_PW_SDIV, ST_PW_SW, ST_EU_CHK, ST_EU_DIV, ST_EU_W, ST_EU_MUL, ST_EU_UPD,
		ST_EU_FIX, ST_M1_DIV, ST_M1_W, ST_M2_DIV, ST_M2_W, ST_ADD, ST_DONE
	} state_t;

endpackage
`default_nettype wire

### rtl/crtmp_divider.sv
`default_nettype none
module crtmp_divider (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  crtmp_pkg::div_req_t      req,
	output crtmp_pkg::div_rsp_t      rsp
);

	logic [crtmp_pkg::CNT_BITS-1:0]  cnt_q;
	logic [crtmp_pkg::DBL_BITS-1:0]  quo_q;
	logic [crtmp_pkg::WORD_BITS-1:0] rem_q;
	logic [crtmp_pkg::WORD_BITS-1:0] dvs_q;
	logic                            done_q;
	logic [crtmp_pkg::WORD_BITS:0]   trial;
	logic                            fits;

	// restoring divide, one quotient bit a cycle
	assign trial = {rem_q, quo_q[crtmp_pkg::DBL_BITS-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= req.wide ? crtmp_pkg::CNT_BITS'(crtmp_pkg::DBL_BITS)
				                  : crtmp_pkg::CNT_BITS'(crtmp_pkg::WORD_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == crtmp_pkg::CNT_BITS'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			// narrow operands sit in the top half so only half the steps are needed
			quo_q <= req.wide ? req.dividend
			                  : {req.dividend[crtmp_pkg::WORD_BITS-1:0],
			                     {crtmp_pkg::WORD_BITS{1'b0}}};
		end else if (cnt_q != '0) begin
			rem_q <= fits ? crtmp_pkg::WORD_BITS'(trial - {1'b0, dvs_q})
			              : trial[crtmp_pkg::WORD_BITS-1:0];
			quo_q <= {quo_q[crtmp_pkg::DBL_BITS-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q[crtmp_pkg::WORD_BITS-1:0];
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

### rtl/crtmp_seq.sv
`default_nettype none
module crtmp_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [crtmp_pkg::WORD_BITS-1:0] base,
	input  wire logic [crtmp_pkg::WORD_BITS-1:0] exponent,
	input  wire logic [crtmp_pkg::WORD_BITS-1:0] modulus,
	input  wire logic                        out_free,
	output crtmp_pkg::seq_stat_t             stat,
	output logic [crtmp_pkg::WORD_BITS-1:0]  acc
);

	localparam int W = crtmp_pkg::WORD_BITS;
	localparam int S = crtmp_pkg::S_BITS;

	crtmp_pkg::state_t state_q, state_d;
	crtmp_pkg::div_req_t req;
	crtmp_pkg::div_rsp_t rsp;

	logic [W-1:0] x_q, e_q, n_q, rest_q, p_q, cof_q, r_q, xr_q, t_q, inv_q, acc_q;
	logic [W-1:0] rp_q, rc_q, rn_q, qt_q;
	logic [crtmp_pkg::D_BITS-1:0]   d_q;
	logic [crtmp_pkg::IDX_BITS-1:0] idx_q;
	logic signed [S-1:0] sp_q, sc_q;
	logic [2*W-1:0] prod_q;
	logic           tail_q;

	logic [W-1:0]   mul_a, mul_b;
	logic [2*W-1:0] mul_p;
	logic [W-1:0]   sc_abs;
	logic signed [S-1:0] s_next, s_fix;
	logic [W:0]     sum;

	crtmp_divider u_div (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	assign sc_abs = sc_q[S-1] ? W'(-sc_q) : W'(sc_q);
	assign mul_p  = mul_a * mul_b;
	assign s_next = sc_q[S-1] ? sp_q + signed'(prod_q[S-1:0])
	                          : sp_q - signed'(prod_q[S-1:0]);
	assign sum    = {1'b0, acc_q} + {1'b0, t_q};

	always_comb begin
		s_fix = sc_q[S-1] ? sc_q + signed'(S'(p_q)) : sc_q;
		if (s_fix >= signed'(S'(p_q)))
			s_fix = s_fix - signed'(S'(p_q));
	end

	// shared multiplier operands
	always_comb begin
		case (state_q)
			crtmp_pkg::ST_TR_CHK:  begin mul_a = W'(d_q); mul_b = W'(d_q); end
			crtmp_pkg::ST_FA_W:    begin mul_a = p_q;     mul_b = W'(d_q); end
			crtmp_pkg::ST_PW_MDIV: begin mul_a = r_q;     mul_b = xr_q;    end
			crtmp_pkg::ST_PW_SDIV: begin mul_a = xr_q;    mul_b = xr_q;    end
			crtmp_pkg::ST_EU_MUL:  begin mul_a = qt_q;    mul_b = sc_abs;  end
			crtmp_pkg::ST_M1_DIV:  begin mul_a = r_q;     mul_b = cof_q;   end
			crtmp_pkg::ST_M2_DIV:  begin mul_a = t_q;     mul_b = inv_q;   end
			default:               begin mul_a = '0;      mul_b = '0;      end
		endcase
	end

	// divider requests
	always_comb begin
		req = '0;
		case (state_q)
			crtmp_pkg::ST_TR_DIV, crtmp_pkg::ST_FA_DIV: begin
				req.start = 1'b1; req.dividend = (2*W)'(rest_q); req.divisor = W'(d_q);
			end
			crtmp_pkg::ST_CO_DIV: begin
				req.start = 1'b1; req.dividend = (2*W)'(n_q); req.divisor = p_q;
			end
			crtmp_pkg::ST_XM_DIV: begin
				req.start = 1'b1; req.dividend = (2*W)'(x_q); req.divisor = p_q;
			end
			crtmp_pkg::ST_PW_MDIV, crtmp_pkg::ST_PW_SDIV: begin
				req.start = 1'b1; req.wide = 1'b1; req.dividend = mul_p; req.divisor = p_q;
			end
			crtmp_pkg::ST_EU_DIV: begin
				req.start = 1'b1; req.dividend = (2*W)'(rp_q); req.divisor = rc_q;
			end
			crtmp_pkg::ST_M1_DIV, crtmp_pkg::ST_M2_DIV: begin
				req.start = 1'b1; req.wide = 1'b1; req.dividend = mul_p; req.divisor = n_q;
			end
			default: req = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			crtmp_pkg::ST_IDLE:
				if (start)
					state_d = (modulus <= W'(1)) ? crtmp_pkg::ST_DONE : crtmp_pkg::ST_TR_CHK;
			crtmp_pkg::ST_TR_CHK:
				state_d = (mul_p > (2*W)'(rest_q)) ? crtmp_pkg::ST_TAIL : crtmp_pkg::ST_TR_DIV;
			crtmp_pkg::ST_TR_DIV: state_d = crtmp_pkg::ST_TR_W;
			crtmp_pkg::ST_TR_W:
				if (rsp.done)
					state_d = (rsp.rem == '0) ? crtmp_pkg::ST_FA_DIV : crtmp_pkg::ST_TR_CHK;
			crtmp_pkg::ST_FA_DIV: state_d = crtmp_pkg::ST_FA_W;
			crtmp_pkg::ST_FA_W:
				if (rsp.done)
					state_d = (rsp.rem == '0) ? crtmp_pkg::ST_FA_DIV : crtmp_pkg::ST_CO_DIV;
			crtmp_pkg::ST_TAIL:
				state_d = (rest_q > W'(1)) ? crtmp_pkg::ST_CO_DIV : crtmp_pkg::ST_DONE;
			crtmp_pkg::ST_CO_DIV: state_d = crtmp_pkg::ST_CO_W;
			crtmp_pkg::ST_CO_W:   if (rsp.done) state_d = crtmp_pkg::ST_XM_DIV;
			crtmp_pkg::ST_XM_DIV: state_d = crtmp_pkg::ST_XM_W;
			crtmp_pkg::ST_XM_W:   if (rsp.done) state_d = crtmp_pkg::ST_PW_CHK;
			crtmp_pkg::ST_PW_CHK:
				if (idx_q == crtmp_pkg::IDX_BITS'(W))
					state_d = crtmp_pkg::ST_EU_CHK;
				else if (e_q[idx_q[crtmp_pkg::IDX_BITS-2:0]])
					state_d = crtmp_pkg::ST_PW_MDIV;
				else
					state_d = crtmp_pkg::ST_PW_SDIV;
			crtmp_pkg::ST_PW_MDIV: state_d = crtmp_pkg::ST_PW_MW;
			crtmp_pkg::ST_PW_MW:   if (rsp.done) state_d = crtmp_pkg::ST_PW_SDIV;
			crtmp_pkg::ST_PW_SDIV: state_d = crtmp_pkg::ST_PW_SW;
			crtmp_pkg::ST_PW_SW:   if (rsp.done) state_d = crtmp_pkg::ST_PW_CHK;
			crtmp_pkg::ST_EU_CHK:
				if (rc_q == '0)
					state_d = crtmp_pkg::ST_M1_DIV;
				else if (rc_q == W'(1))
					state_d = crtmp_pkg::ST_EU_FIX;
				else
					state_d = crtmp_pkg::ST_EU_DIV;
			crtmp_pkg::ST_EU_DIV: state_d = crtmp_pkg::ST_EU_W;
			crtmp_pkg::ST_EU_W:   if (rsp.done) state_d = crtmp_pkg::ST_EU_MUL;
			crtmp_pkg::ST_EU_MUL: state_d = crtmp_pkg::ST_EU_UPD;
			crtmp_pkg::ST_EU_UPD: state_d = crtmp_pkg::ST_EU_CHK;
			crtmp_pkg::ST_EU_FIX: state_d = crtmp_pkg::ST_M1_DIV;
			crtmp_pkg::ST_M1_DIV: state_d = crtmp_pkg::ST_M1_W;
			crtmp_pkg::ST_M1_W:   if (rsp.done) state_d = crtmp_pkg::ST_M2_DIV;
			crtmp_pkg::ST_M2_DIV: state_d = crtmp_pkg::ST_M2_W;
			crtmp_pkg::ST_M2_W:   if (rsp.done) state_d = crtmp_pkg::ST_ADD;
			crtmp_pkg::ST_ADD:
				state_d = tail_q ? crtmp_pkg::ST_DONE : crtmp_pkg::ST_TR_CHK;
			crtmp_pkg::ST_DONE:   if (out_free) state_d = crtmp_pkg::ST_IDLE;
			default:              state_d = crtmp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		stat.ready = state_q == crtmp_pkg::ST_IDLE;
		stat.done  = state_q == crtmp_pkg::ST_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= crtmp_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			crtmp_pkg::ST_IDLE: begin
				x_q    <= base;
				e_q    <= exponent;
				n_q    <= modulus;
				rest_q <= modulus;
				d_q    <= crtmp_pkg::D_BITS'(crtmp_pkg::FIRST_DIVISOR);
				acc_q  <= '0;
				tail_q <= 1'b0;
			end
			crtmp_pkg::ST_TR_W:
				if (rsp.done) begin
					if (rsp.rem == '0) begin
						p_q    <= W'(d_q);
						rest_q <= rsp.quo;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
			crtmp_pkg::ST_FA_W:
				if (rsp.done && rsp.rem == '0) begin
					p_q    <= mul_p[W-1:0];
					rest_q <= rsp.quo;
				end
			crtmp_pkg::ST_TAIL: begin
				p_q    <= rest_q;
				tail_q <= 1'b1;
			end
			crtmp_pkg::ST_CO_W:
				if (rsp.done) cof_q <= rsp.quo;
			crtmp_pkg::ST_XM_W:
				if (rsp.done) begin
					xr_q  <= rsp.rem;
					r_q   <= W'(1);
					idx_q <= '0;
					sp_q  <= '0;
					sc_q  <= S'(1);
					rp_q  <= p_q;
					rc_q  <= cof_q;
				end
			crtmp_pkg::ST_PW_MW:
				if (rsp.done) r_q <= rsp.rem;
			crtmp_pkg::ST_PW_SW:
				if (rsp.done) begin
					xr_q  <= rsp.rem;
					idx_q <= idx_q + 1'b1;
				end
			crtmp_pkg::ST_EU_CHK:
				if (rc_q == '0) inv_q <= '0;
			crtmp_pkg::ST_EU_W:
				if (rsp.done) begin
					qt_q <= rsp.quo;
					rn_q <= rsp.rem;
				end
			crtmp_pkg::ST_EU_MUL:
				prod_q <= mul_p;
			crtmp_pkg::ST_EU_UPD: begin
				sp_q <= sc_q;
				sc_q <= s_next;
				rp_q <= rc_q;
				rc_q <= rn_q;
			end
			crtmp_pkg::ST_EU_FIX:
				inv_q <= s_fix[W-1:0];
			crtmp_pkg::ST_M1_W, crtmp_pkg::ST_M2_W:
				if (rsp.done) t_q <= rsp.rem;
			crtmp_pkg::ST_ADD: begin
				// each term is folded back below the modulus as it is added
				acc_q <= (sum >= {1'b0, n_q}) ? W'(sum - {1'b0, n_q}) : sum[W-1:0];
				if (!tail_q) d_q <= d_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

### rtl/crt_modular_power.sv
// Run time: data dependent; trial division of the modulus (each candidate mostly a 32-step pass
// of the shared divider) dominates.
// Each prime-power factor adds 32 square-and-multiply rounds of 64-step divides, then the
// Euclidean steps.
// Throughput: one item at a time; in_ready is low while an item is in work.
// Reset: arst_n clears the sequencer, divider count and output valid; no clearing pass.
`default_nettype none
module crt_modular_power (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [crtmp_pkg::WORD_BITS-1:0]      base,
	input  wire logic [crtmp_pkg::WORD_BITS-1:0]      exponent,
	input  wire logic [crtmp_pkg::WORD_BITS-1:0]      modulus,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [crtmp_pkg::WORD_BITS-1:0]           result
);

	crtmp_pkg::seq_stat_t            stat;
	logic [crtmp_pkg::WORD_BITS-1:0] acc;
	logic                            out_valid_q;
	logic [crtmp_pkg::WORD_BITS-1:0] result_q;
	logic                            out_free;
	logic                            in_fire;

	assign out_free = !out_valid_q || out_ready;
	assign in_fire  = in_valid && stat.ready;

	crtmp_seq u_seq (
		.clk(clk), .arst_n(arst_n), .start(in_fire),
		.base(base), .exponent(exponent), .modulus(modulus),
		.out_free(out_free), .stat(stat), .acc(acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (stat.done && out_free)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (stat.done && out_free)
			result_q <= acc;
	end

	assign in_ready  = stat.ready;
	assign out_valid = out_valid_q;
	assign result    = result_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready) else $error("took a second item while busy");
	a_done_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> !stat.ready) else $error("done and ready together");
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> result_q != '1) else $error("result not reduced");
`endif

endmodule
`default_nettype wire

### tb/sv/crt_modular_power_checker.sv
`default_nettype none
module crt_modular_power_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [31:0] base,
	input  wire logic [31:0] exponent,
	input  wire logic [31:0] modulus,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] result,
	output int               errors,
	output int               pending
);
	logic [31:0] expected_results[$];

	function automatic longint unsigned power_mod(longint unsigned x, longint unsigned e,
			longint unsigned p);
		longint unsigned acc;
		acc = 1 % p;
		x = x % p;
		while (e != 0) begin
			if (e[0])
				acc = (acc * x) % p;
			e = e >> 1;
			x = (x * x) % p;
		end
		return acc;
	endfunction

	function automatic longint unsigned cofactor_inverse(longint unsigned p, longint unsigned c);
		longint s_old, r_old, s_now, r_now, q, s_nxt, r_nxt, pm;
		s_old = 0;
		r_old = longint'(p);
		s_now = 1;
		r_now = longint'(c);
		while (r_now != 0 && r_now != 1) begin
			q = r_old / r_now;
			s_nxt = s_old - q * s_now;
			r_nxt = r_old - q * r_now;
			s_old = s_now;
			r_old = r_now;
			s_now = s_nxt;
			r_now = r_nxt;
		end
		if (r_now == 0)
			return 0;
		pm = longint'(p);
		return longint'(((s_now % pm) + pm) % pm);
	endfunction

	function automatic longint unsigned crt_term(longint unsigned acc, longint unsigned x,
			longint unsigned e, longint unsigned n, longint unsigned p);
		longint unsigned cof, r, inv, t;
		cof = n / p;
		r = power_mod(x, e, p);
		inv = cofactor_inverse(p, cof);
		t = (((r * cof) % n) * inv) % n;
		return (acc + t) % n;
	endfunction

	function automatic logic [31:0] crt_power(logic [31:0] b, logic [31:0] e, logic [31:0] m);
		longint unsigned rest, d, p, acc, n;
		n = m;
		acc = 0;
		if (n <= 1)
			return '0;
		rest = n;
		for (d = crtmp_pkg::FIRST_DIVISOR; d * d <= rest; d++) begin
			if (rest % d == 0) begin
				p = 1;
				while (rest % d == 0) begin
					p = p * d;
					rest = rest / d;
				end
				acc = crt_term(acc, b, e, n, p);
			end
		end
		if (rest > 1)
			acc = crt_term(acc, b, e, n, rest);
		return acc[31:0];
	endfunction

	assign pending = expected_results.size();

	initial errors = 0;

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(),
					crt_power(base, exponent, modulus));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h", result);
				end else begin
					want = expected_results.pop_front();
					if (result !== want) begin
						errors++;
						if (errors <= 10)
							$display("result mismatch: expected %h, got %h", want, result);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

### tb/sv/crt_modular_power_tb.sv
`default_nettype none
module crt_modular_power_tb;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [31:0] base = '0;
	logic [31:0] exponent = '0;
	logic [31:0] modulus = 32'd1;
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] result;
	logic        calm = 0;
	int          errors;
	int          pending;

	crt_modular_power dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.base(base), .exponent(exponent), .modulus(modulus),
		.out_valid(out_valid), .out_ready(out_ready), .result(result)
	);

	crt_modular_power_checker chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.base(base), .exponent(exponent), .modulus(modulus),
		.out_valid(out_valid), .out_ready(out_ready), .result(result),
		.errors(errors), .pending(pending)
	);

	always #1 clk = ~clk;

	// receiver stalls in bursts
	always @(posedge clk) begin
		int n;
		if (!calm && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 8);
			out_ready <= 0;
			repeat (n) @(posedge clk);
		end
		out_ready <= 1;
	end

	task automatic send_item(logic [31:0] b, logic [31:0] e, logic [31:0] m);
		int n;
		if (!calm && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 8);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		base <= b;
		exponent <= e;
		modulus <= m;
		do @(posedge clk); while (!in_ready);
	endtask

	// mostly cheap moduli: small, or a small odd part times a power of two
	function automatic logic [31:0] pick_modulus();
		logic [31:0] m;
		if ($urandom_range(0, 1) == 0)
			m = $urandom_range(1, 65535);
		else
			m = 32'($urandom_range(1, 255)) << $urandom_range(0, 24);
		return m;
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_item(32'd7, 32'd0, 32'd13);
		send_item(32'd7, 32'd0, 32'd1);
		send_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1);
		send_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_item(32'd0, 32'd5, 32'd1000);
		send_item(32'd0, 32'd0, 32'd1000);
		send_item(32'd3, 32'd200, 32'd2);
		send_item(32'hDEADBEEF, 32'h12345678, 32'h80000000);
		send_item(32'h12345678, 32'hFFFFFFFF, 32'd3486784401);
		send_item(32'h87654321, 32'hA5A5A5A5, 32'd4294967291);
		send_item(32'd2, 32'd31, 32'd65536);
		send_item(32'd12, 32'd3, 32'd360);
		send_item(32'hFFFFFFFF, 32'd1, 32'd65537);
		send_item(32'd5, 32'hFFFFFFFF, 32'd97);
		for (int i = 0; i < 100; i++) begin
			if (i == 85)
				calm = 1;
			send_item($urandom, $urandom, pick_modulus());
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#80000000;
		$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
